// ===== rtl/core/elgamal_decrypt_defines.svh =====
// ----------------------------------------------------------------------------
// ElGamal decryption assertion macros
// Shared property forms for the decryption core checks.
// ----------------------------------------------------------------------------
`ifndef ELGAMAL_DECRYPT_DEFINES_SVH
`define ELGAMAL_DECRYPT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ED_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("elgamal_decrypt: same-cycle check failed");

// next-cycle implication, disabled in reset
`define ED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("elgamal_decrypt: next-cycle check failed");

`endif

// ===== rtl/core/eldec_pkg.sv =====
// ----------------------------------------------------------------------------
// eldec_pkg
// Constants shared by the ElGamal decryption core.
// ----------------------------------------------------------------------------
`default_nettype none

package eldec_pkg;

  localparam int MOD_WIDTH_DEF = 31;
  localparam int CFG_INDEX_W   = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 1'b1;

  localparam logic [30:0] MODULUS_RESET  = 31'd23;
  localparam logic [30:0] EXPONENT_RESET = 31'd1;

endpackage

`default_nettype wire

// ===== rtl/core/elgamal_decrypt.sv =====
// ----------------------------------------------------------------------------
// elgamal_decrypt
// ElGamal decryption: plaintext = cipher_second * (cipher_first^x)^(p-2) mod p.
// ----------------------------------------------------------------------------
// One shared bit-serial modular multiplier (double, add, conditional
// subtract; one multiplier bit per cycle) does all the arithmetic under a
// small sequencer. An item costs at most (3 + bitlen(x) + popcount(x) +
// bitlen(p-2) + popcount(p-2)) modular products: two input reductions,
// the two exponentiations and the final product. in_stall is high from
// the accepted input transfer until the result transfer completes.
// A modulus below 2 gives plaintext 0 in the cycle after the input transfer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "elgamal_decrypt_defines.svh"

module elgamal_decrypt #(
  parameter int MOD_WIDTH = eldec_pkg::MOD_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [eldec_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [MOD_WIDTH-1:0]               cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [MOD_WIDTH-1:0]               cipher_first,
  input  wire logic [MOD_WIDTH-1:0]               cipher_second,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [MOD_WIDTH-1:0]                    plaintext
);

  import eldec_pkg::*;

  localparam int W     = MOD_WIDTH;
  localparam int CNT_W = $clog2(W);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_EXP, S_OUT} state_t;
  typedef enum logic [2:0] {OP_RED1, OP_RED2, OP_ACC, OP_SQ, OP_FIN} op_t;

  state_t             state;
  op_t                op;
  logic               inv_phase;
  logic [W-1:0]       modulus;
  logic [W-1:0]       private_exponent;
  logic [W-1:0]       p_q;
  logic [W-1:0]       expo;
  logic [W-1:0]       base;
  logic [W-1:0]       acc;
  logic [W-1:0]       c2;
  logic [W-1:0]       m_a;
  logic [W-1:0]       m_b;
  logic [W-1:0]       m_acc;
  logic [CNT_W-1:0]   m_cnt;
  logic [W-1:0]       result;

  logic [W:0]         dbl;
  logic [W-1:0]       dbl_r;
  logic [W:0]         sum;
  logic [W-1:0]       res;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= MODULUS_RESET[W-1:0];
      private_exponent <= EXPONENT_RESET[W-1:0];
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:  modulus <= cfg_data;
        REG_EXPONENT: private_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // one interleaved step: acc = (2*acc + bit*a) mod p, with acc, a < p
  always_comb begin
    dbl   = {m_acc, 1'b0};
    dbl_r = (dbl >= {1'b0, p_q}) ? W'(dbl - {1'b0, p_q}) : dbl[W-1:0];
    sum   = {1'b0, dbl_r} + {1'b0, (m_b[W-1] ? m_a : '0)};
    res   = (sum >= {1'b0, p_q}) ? W'(sum - {1'b0, p_q}) : sum[W-1:0];
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign plaintext = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_RED1;
      inv_phase <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            p_q <= modulus;
            c2  <= cipher_second;
            if (modulus < W'(2)) begin
              result <= '0;
              state  <= S_OUT;
            end else begin
              expo      <= private_exponent;
              inv_phase <= 1'b0;
              m_a       <= W'(1);
              m_b       <= cipher_first;
              m_acc     <= '0;
              m_cnt     <= CNT_W'(W - 1);
              op        <= OP_RED1;
              state     <= S_MUL;
            end
          end
        end
        S_MUL: begin
          m_acc <= res;
          m_b   <= {m_b[W-2:0], 1'b0};
          m_cnt <= m_cnt - CNT_W'(1);
          if (m_cnt == '0) begin
            m_acc <= '0;
            m_cnt <= CNT_W'(W - 1);
            case (op)
              OP_RED1: begin
                base <= res;
                m_a  <= W'(1);
                m_b  <= c2;
                op   <= OP_RED2;
              end
              OP_RED2: begin
                c2    <= res;
                acc   <= W'(1);
                state <= S_EXP;
              end
              OP_ACC: begin
                acc <= res;
                m_a <= base;
                m_b <= base;
                op  <= OP_SQ;
              end
              OP_SQ: begin
                base  <= res;
                expo  <= expo >> 1;
                state <= S_EXP;
              end
              OP_FIN: begin
                result <= res;
                state  <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_EXP: begin
          m_acc <= '0;
          m_cnt <= CNT_W'(W - 1);
          if (expo == '0) begin
            if (!inv_phase) begin
              if (acc == '0) begin
                result <= '0;
                state  <= S_OUT;
              end else begin
                base      <= acc;
                acc       <= W'(1);
                expo      <= p_q - W'(2);
                inv_phase <= 1'b1;
              end
            end else begin
              m_a   <= c2;
              m_b   <= acc;
              op    <= OP_FIN;
              state <= S_MUL;
            end
          end else if (expo[0]) begin
            m_a   <= acc;
            m_b   <= base;
            op    <= OP_ACC;
            state <= S_MUL;
          end else begin
            m_a   <= base;
            m_b   <= base;
            op    <= OP_SQ;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ED_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `ED_ASSERT_NOW(a_result_reduced, clk, rst, out_valid,
                 (plaintext < p_q) || (plaintext == '0))
  `ED_ASSERT_NOW(a_mul_acc_reduced, clk, rst, state == S_MUL,
                 (m_acc < p_q) && (m_a < p_q))
  `ED_ASSERT_NOW(a_exp_operands_reduced, clk, rst, state == S_EXP,
                 (acc < p_q) && (base < p_q))

endmodule

`default_nettype wire
